### sv/tsdc_pkg.sv
`default_nettype none
package tsdc_pkg;

  localparam int NUM_CH    = 3;
  localparam int TEMP_W    = 12;
  localparam int TMR_W     = 8;
  localparam int LVL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  localparam logic [LVL_W-1:0] LVL_IDLE   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd1;
  localparam logic [LVL_W-1:0] LVL_WARN   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_CRIT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME   = 3'd5;

  localparam logic signed [TEMP_W-1:0] RST_NORMAL_THR = 12'sd650;
  localparam logic signed [TEMP_W-1:0] RST_WARN_THR   = 12'sd749;
  localparam logic signed [TEMP_W-1:0] RST_CRIT_THR   = 12'sd949;
  localparam logic [TMR_W-1:0]         RST_WARN_PER   = 8'd100;
  localparam logic [TMR_W-1:0]         RST_ON_TIME    = 8'd50;
  localparam logic [TMR_W-1:0]         RST_OFF_TIME   = 8'd150;

  typedef struct packed {
    logic signed [TEMP_W-1:0] normal_thr;
    logic signed [TEMP_W-1:0] warn_thr;
    logic signed [TEMP_W-1:0] crit_thr;
  } thr_t;

  // shared timing decisions, taken from the timers at the start of a tick
  typedef struct packed {
    logic manual;
    logic long_due;
    logic on_due;
    logic off_due;
  } lane_ctl_t;

  typedef struct packed {
    logic             open_nxt;
    logic [LVL_W-1:0] level;
    logic             long_hit;
    logic             short_hit;
  } lane_res_t;

  typedef struct packed {
    logic [NUM_CH-1:0]            open;
    logic [NUM_CH-1:0][LVL_W-1:0] level;
  } out_res_t;

endpackage
`default_nettype wire

### sv/thermal_solenoid_duty_controller.sv
`default_nettype none
// Channel  Direction  Handshake             Beat carries
// in       input      in_valid/in_ready     three temperatures, manual flag
// out      output     out_valid/out_ready   three solenoid drives, three levels
// cfg      input      cfg_valid/cfg_ready   register index, write data
//
// One beat per clock sustained while out_ready stays high: a tick's result is
// registered at the edge that accepts its input beat; the three lanes and the timer merge are combinational.
// A two-entry output buffer (output register plus skid) keeps in_ready high
// while one result waits; in_ready falls only when both entries are full.
// Reset (rst_n low, synchronous) closes all solenoids, clears both timers,
// empties the output buffer and loads the register defaults.
module thermal_solenoid_duty_controller (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input ticks
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [tsdc_pkg::TEMP_W-1:0]    in_left_temp,
  input  wire logic signed [tsdc_pkg::TEMP_W-1:0]    in_right_temp,
  input  wire logic signed [tsdc_pkg::TEMP_W-1:0]    in_brake_temp,
  input  wire logic                                  in_manual_mode,
  // results
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       out_left_open,
  output logic                                       out_right_open,
  output logic                                       out_brake_open,
  output logic [tsdc_pkg::LVL_W-1:0]                 out_left_level,
  output logic [tsdc_pkg::LVL_W-1:0]                 out_right_level,
  output logic [tsdc_pkg::LVL_W-1:0]                 out_brake_level,
  // register writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tsdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tsdc_pkg::CFG_DAT_W-1:0]        cfg_data
);

  tsdc_pkg::thr_t                                 thr_r;
  logic [tsdc_pkg::TMR_W-1:0]                     warn_per_r;
  logic [tsdc_pkg::TMR_W-1:0]                     on_time_r;
  logic [tsdc_pkg::TMR_W-1:0]                     off_time_r;

  logic signed [tsdc_pkg::TEMP_W-1:0]             temp [tsdc_pkg::NUM_CH];
  tsdc_pkg::lane_ctl_t                            ctl;
  tsdc_pkg::lane_res_t [tsdc_pkg::NUM_CH-1:0]     lane_res;
  logic [tsdc_pkg::NUM_CH-1:0]                    open_r;
  tsdc_pkg::out_res_t                             res;

  tsdc_pkg::out_res_t                             out_r, skid_r;
  logic                                           out_v_r, skid_v_r;
  logic                                           acc, pop;

  // Register writes are always taken; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.normal_thr <= tsdc_pkg::RST_NORMAL_THR;
      thr_r.warn_thr   <= tsdc_pkg::RST_WARN_THR;
      thr_r.crit_thr   <= tsdc_pkg::RST_CRIT_THR;
      warn_per_r       <= tsdc_pkg::RST_WARN_PER;
      on_time_r        <= tsdc_pkg::RST_ON_TIME;
      off_time_r       <= tsdc_pkg::RST_OFF_TIME;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsdc_pkg::REG_NORMAL_THR: thr_r.normal_thr <= cfg_data[tsdc_pkg::TEMP_W-1:0];
        tsdc_pkg::REG_WARN_THR:   thr_r.warn_thr   <= cfg_data[tsdc_pkg::TEMP_W-1:0];
        tsdc_pkg::REG_CRIT_THR:   thr_r.crit_thr   <= cfg_data[tsdc_pkg::TEMP_W-1:0];
        tsdc_pkg::REG_WARN_PER:   warn_per_r       <= cfg_data[tsdc_pkg::TMR_W-1:0];
        tsdc_pkg::REG_ON_TIME:    on_time_r        <= cfg_data[tsdc_pkg::TMR_W-1:0];
        tsdc_pkg::REG_OFF_TIME:   off_time_r       <= cfg_data[tsdc_pkg::TMR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Lane order: left, right, brake.
  assign temp[0] = in_left_temp;
  assign temp[1] = in_right_temp;
  assign temp[2] = in_brake_temp;

  for (genvar c = 0; c < tsdc_pkg::NUM_CH; c++) begin : g_lane
    tsdc_lane u_lane (
      .temp   (temp[c]),
      .thr    (thr_r),
      .ctl    (ctl),
      .open_r (open_r[c]),
      .res    (lane_res[c])
    );
  end

  tsdc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .manual   (in_manual_mode),
    .warn_per (warn_per_r),
    .on_time  (on_time_r),
    .off_time (off_time_r),
    .lane_res (lane_res),
    .ctl      (ctl),
    .open_r   (open_r),
    .res      (res)
  );

  // Take a beat unless the skid entry is occupied.
  assign in_ready = !skid_v_r;
  assign acc      = in_valid && in_ready;
  assign pop      = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        // advance the parked result once the output drains
        if (pop) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (acc) begin
        if (out_v_r && !pop) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (acc) begin
      if (out_v_r && !pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_left_open   = out_r.open[0];
  assign out_right_open  = out_r.open[1];
  assign out_brake_open  = out_r.open[2];
  assign out_left_level  = out_r.level[0];
  assign out_right_level = out_r.level[1];
  assign out_brake_level = out_r.level[2];

endmodule
`default_nettype wire

### sv/tsdc_lane.sv
`default_nettype none
// One channel: classify the temperature and decide the solenoid's next state.
module tsdc_lane (
  input  wire logic signed [tsdc_pkg::TEMP_W-1:0] temp,
  input  wire tsdc_pkg::thr_t                     thr,
  input  wire tsdc_pkg::lane_ctl_t                ctl,
  input  wire logic                               open_r,
  output tsdc_pkg::lane_res_t                     res
);

  logic [tsdc_pkg::LVL_W-1:0] level;

  always_comb begin
    if (temp > thr.crit_thr) begin
      level = tsdc_pkg::LVL_CRIT;
    end else if (temp > thr.warn_thr) begin
      level = tsdc_pkg::LVL_WARN;
    end else if (temp > thr.normal_thr) begin
      level = tsdc_pkg::LVL_NORMAL;
    end else begin
      level = tsdc_pkg::LVL_IDLE;
    end
  end

  always_comb begin
    res.level     = level;
    res.open_nxt  = open_r;
    res.long_hit  = 1'b0;
    res.short_hit = 1'b0;
    if (!ctl.manual) begin
      case (level)
        tsdc_pkg::LVL_CRIT: begin
          res.open_nxt = 1'b1;
        end
        tsdc_pkg::LVL_WARN: begin
          if (ctl.long_due) begin
            res.open_nxt = ~open_r;
            res.long_hit = 1'b1;
          end
        end
        tsdc_pkg::LVL_NORMAL: begin
          // at most one transition: an open solenoid may only close
          if (open_r) begin
            if (ctl.on_due) begin
              res.open_nxt  = 1'b0;
              res.short_hit = 1'b1;
            end
          end else if (ctl.off_due) begin
            res.open_nxt  = 1'b1;
            res.short_hit = 1'b1;
          end
        end
        default: begin
          res.open_nxt = 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/tsdc_merge.sv
`default_nettype none
// Combine the lanes: hold solenoid and timer state, reset timers on a hit.
module tsdc_merge (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           acc,
  input  wire logic                                           manual,
  input  wire logic [tsdc_pkg::TMR_W-1:0]                     warn_per,
  input  wire logic [tsdc_pkg::TMR_W-1:0]                     on_time,
  input  wire logic [tsdc_pkg::TMR_W-1:0]                     off_time,
  input  wire tsdc_pkg::lane_res_t [tsdc_pkg::NUM_CH-1:0]     lane_res,
  output tsdc_pkg::lane_ctl_t                                 ctl,
  output logic [tsdc_pkg::NUM_CH-1:0]                         open_r,
  output tsdc_pkg::out_res_t                                  res
);

  logic [tsdc_pkg::NUM_CH-1:0] open_nxt;
  logic [tsdc_pkg::TMR_W-1:0]  long_r, long_nxt;
  logic [tsdc_pkg::TMR_W-1:0]  short_r, short_nxt;
  logic                        long_hit, short_hit;

  assign ctl.manual   = manual;
  assign ctl.long_due = long_r > warn_per;
  assign ctl.on_due   = short_r > on_time;
  assign ctl.off_due  = short_r > off_time;

  always_comb begin
    long_hit  = 1'b0;
    short_hit = 1'b0;
    for (int c = 0; c < tsdc_pkg::NUM_CH; c++) begin
      open_nxt[c]  = lane_res[c].open_nxt;
      res.level[c] = lane_res[c].level;
      long_hit     = long_hit | lane_res[c].long_hit;
      short_hit    = short_hit | lane_res[c].short_hit;
    end
    res.open = open_nxt;
    // saturate at full scale
    long_nxt  = long_hit ? '0 : ((long_r == '1) ? long_r : long_r + 1'b1);
    short_nxt = short_hit ? '0 : ((short_r == '1) ? short_r : short_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= '0;
      long_r  <= '0;
      short_r <= '0;
    end else if (acc) begin
      open_r  <= open_nxt;
      long_r  <= long_nxt;
      short_r <= short_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/tsdc_checker.sv
`default_nettype none
module tsdc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_manual_mode,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_left_open,
  input wire logic [tsdc_pkg::LVL_W-1:0]   out_left_level
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_open)
      && $stable(out_left_level))
    else $error("stalled output beat changed");

  // input is only back-pressured when a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // an accepted beat into a free output shows up in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) |=> out_valid)
    else $error("result missing one cycle after accept");

  // in automatic mode critical opens and idle closes the solenoid
  a_level_drive: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_manual_mode && (!out_valid || out_ready) |=>
      (out_left_level != tsdc_pkg::LVL_CRIT || out_left_open)
      && (out_left_level != tsdc_pkg::LVL_IDLE || !out_left_open))
    else $error("solenoid drive disagrees with level");

endmodule

bind thermal_solenoid_duty_controller tsdc_checker u_tsdc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_manual_mode (in_manual_mode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_left_open  (out_left_open),
  .out_left_level (out_left_level)
);
`default_nettype wire

### tb/sv/tb_thermal_solenoid_duty_controller.sv
module tb_thermal_solenoid_duty_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // Register slots past the last defined one; writes there must change nothing.
  localparam logic [tsdc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tsdc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int TEMP_MIN  = -2048;
  localparam int TEMP_MAX  = 2047;
  localparam int OPER_MIN  = -550;
  localparam int OPER_MAX  = 2000;
  localparam int STALL_CAP = 2000;  // cycles without any beat before giving up
  localparam int TAIL_CYC  = 8;

  // One control tick as it is queued for the driver.
  typedef struct packed {
    logic                                               manual;
    logic                                               drain_first;  // wait for all results
    logic [tsdc_pkg::NUM_CH-1:0][tsdc_pkg::TEMP_W-1:0]  temp;  // 0 left, 1 right, 2 brake
  } tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [tsdc_pkg::TEMP_W-1:0] in_left_temp = '0;
  logic signed [tsdc_pkg::TEMP_W-1:0] in_right_temp = '0;
  logic signed [tsdc_pkg::TEMP_W-1:0] in_brake_temp = '0;
  logic                               in_manual_mode = 1'b0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_left_open, out_right_open, out_brake_open;
  logic [tsdc_pkg::LVL_W-1:0] out_left_level, out_right_level, out_brake_level;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tsdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tsdc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  thermal_solenoid_duty_controller dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_temp    (in_left_temp),
    .in_right_temp   (in_right_temp),
    .in_brake_temp   (in_brake_temp),
    .in_manual_mode  (in_manual_mode),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_open   (out_left_open),
    .out_right_open  (out_right_open),
    .out_brake_open  (out_brake_open),
    .out_left_level  (out_left_level),
    .out_right_level (out_right_level),
    .out_brake_level (out_brake_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: thresholds, timing registers, solenoids and timers.
  // ---------------------------------------------------------------------------
  logic signed [tsdc_pkg::TEMP_W-1:0] thr_normal = tsdc_pkg::RST_NORMAL_THR;
  logic signed [tsdc_pkg::TEMP_W-1:0] thr_warn   = tsdc_pkg::RST_WARN_THR;
  logic signed [tsdc_pkg::TEMP_W-1:0] thr_crit   = tsdc_pkg::RST_CRIT_THR;
  logic [tsdc_pkg::TMR_W-1:0]         warn_per   = tsdc_pkg::RST_WARN_PER;
  logic [tsdc_pkg::TMR_W-1:0]         on_time    = tsdc_pkg::RST_ON_TIME;
  logic [tsdc_pkg::TMR_W-1:0]         off_time   = tsdc_pkg::RST_OFF_TIME;

  logic [tsdc_pkg::NUM_CH-1:0] drive_open = '0;
  logic [tsdc_pkg::TMR_W-1:0]  long_tmr   = '0;
  logic [tsdc_pkg::TMR_W-1:0]  short_tmr  = '0;

  tick_t               tick_q[$];          // ticks waiting to be driven
  tsdc_pkg::out_res_t  solenoid_exp_q[$];  // predicted solenoid drives and levels, in order
  int                  mism_cnt = 0;
  string               ch_name [tsdc_pkg::NUM_CH] = '{"left", "right", "brake"};

  // Highest level whose test passes wins, so check from the top down.
  function automatic logic [tsdc_pkg::LVL_W-1:0] grade_temp(
    input logic signed [tsdc_pkg::TEMP_W-1:0] t);
    if (t > thr_crit)   return tsdc_pkg::LVL_CRIT;
    if (t > thr_warn)   return tsdc_pkg::LVL_WARN;
    if (t > thr_normal) return tsdc_pkg::LVL_NORMAL;
    return tsdc_pkg::LVL_IDLE;
  endfunction

  function automatic logic [tsdc_pkg::TMR_W-1:0] tmr_bump(
    input logic [tsdc_pkg::TMR_W-1:0] v);
    return (v == {tsdc_pkg::TMR_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Advance the shadow by one tick and return what the block must report.
  // Every decision reads the timers as they stood at the start of the tick.
  function automatic tsdc_pkg::out_res_t advance_solenoids(input tick_t t);
    tsdc_pkg::out_res_t         r;
    logic [tsdc_pkg::LVL_W-1:0] lv;
    logic                       long_due, long_hit, short_hit;
    long_due  = long_tmr > warn_per;
    long_hit  = 1'b0;
    short_hit = 1'b0;
    for (int c = 0; c < tsdc_pkg::NUM_CH; c++) begin
      lv         = grade_temp(t.temp[c]);
      r.level[c] = lv;
      if (!t.manual) begin
        case (lv)
          tsdc_pkg::LVL_CRIT: begin
            drive_open[c] = 1'b1;
          end
          tsdc_pkg::LVL_WARN: begin
            if (long_due) begin
              drive_open[c] = ~drive_open[c];
              long_hit      = 1'b1;
            end
          end
          tsdc_pkg::LVL_NORMAL: begin
            // at most one change: a close here is never followed by a reopen
            if (drive_open[c]) begin
              if (short_tmr > on_time) begin
                drive_open[c] = 1'b0;
                short_hit     = 1'b1;
              end
            end else if (short_tmr > off_time) begin
              drive_open[c] = 1'b1;
              short_hit     = 1'b1;
            end
          end
          default: begin
            drive_open[c] = 1'b0;
          end
        endcase
      end
    end
    long_tmr  = long_hit  ? '0 : tmr_bump(long_tmr);
    short_tmr = short_hit ? '0 : tmr_bump(short_tmr);
    r.open    = drive_open;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat per accepted tick, sent in bursts with random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_ticks
    tick_t acc, nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict the tick that is accepted at this edge.
      if (in_valid && in_ready) begin
        acc.manual      = in_manual_mode;
        acc.drain_first = 1'b0;
        acc.temp[0]     = in_left_temp;
        acc.temp[1]     = in_right_temp;
        acc.temp[2]     = in_brake_temp;
        solenoid_exp_q.push_back(advance_solenoids(acc));
      end
      if (in_valid && !in_ready) begin
        // hold the beat until it is taken
      end else if (tick_q.size() == 0 || gap_left > 0 ||
                   (tick_q[0].drain_first && solenoid_exp_q.size() != 0)) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        nxt = tick_q.pop_front();
        in_valid       <= 1'b1;
        in_left_temp   <= nxt.temp[0];
        in_right_temp  <= nxt.temp[1];
        in_brake_temp  <= nxt.temp[2];
        in_manual_mode <= nxt.manual;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long burst with no gap at all
          if ($urandom_range(7, 0) == 0) begin
            burst_left = $urandom_range(300, 100);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(24, 1);
            gap_left   = $urandom_range(10, 1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall on a rotating ready pattern, check each result beat.
  // ---------------------------------------------------------------------------
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_pos   = 0;

  always @(posedge clk) begin : check_results
    tsdc_pkg::out_res_t ref_res, got;
    if (rst_n && out_valid && out_ready) begin
      got.open  = {out_brake_open, out_right_open, out_left_open};
      got.level = {out_brake_level, out_right_level, out_left_level};
      if (solenoid_exp_q.size() == 0) begin
        $error("result beat with nothing expected: open %b", got.open);
        mism_cnt++;
      end else begin
        ref_res = solenoid_exp_q.pop_front();
        for (int c = 0; c < tsdc_pkg::NUM_CH; c++) begin
          if (got.open[c] !== ref_res.open[c]) begin
            $error("%s_open: expected %0d, got %0d", ch_name[c], ref_res.open[c], got.open[c]);
            mism_cnt++;
          end
          if (got.level[c] !== ref_res.level[c]) begin
            $error("%s_level: expected %0d, got %0d", ch_name[c], ref_res.level[c],
                   got.level[c]);
            mism_cnt++;
          end
        end
      end
    end
    // Rotate the stall pattern; after each full rotation reload it in one of four styles.
    out_ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
    pat_pos++;
    if (pat_pos == 16) begin
      pat_pos = 0;
      case ($urandom_range(3, 0))
        0:       ready_pat = 16'hFFFF;
        1:       ready_pat = 16'($urandom) | 16'h0001;
        2:       ready_pat = 16'($urandom) | 16'($urandom);
        default: ready_pat = (16'($urandom) & 16'($urandom)) | 16'h8000;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no beat moves on any channel for too long.
  // ---------------------------------------------------------------------------
  int quiet_cyc = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cyc = 0;
      else
        quiet_cyc++;
      if (quiet_cyc >= STALL_CAP) begin
        $display("[thermal_solenoid_duty_controller] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Write one register over the cfg channel and mirror it in the shadow.
  // Timing registers get junk in the unused upper data bits.
  task automatic write_reg(input logic [tsdc_pkg::CFG_IDX_W-1:0] idx, input int value);
    logic [tsdc_pkg::CFG_DAT_W-1:0] data;
    data = value[tsdc_pkg::CFG_DAT_W-1:0];
    if (idx == tsdc_pkg::REG_WARN_PER || idx == tsdc_pkg::REG_ON_TIME ||
        idx == tsdc_pkg::REG_OFF_TIME || idx == REG_SPARE_LO || idx == REG_SPARE_HI)
      data[tsdc_pkg::CFG_DAT_W-1:tsdc_pkg::TMR_W] =
        (tsdc_pkg::CFG_DAT_W - tsdc_pkg::TMR_W)'($urandom);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tsdc_pkg::REG_NORMAL_THR: thr_normal = data;
      tsdc_pkg::REG_WARN_THR:   thr_warn   = data;
      tsdc_pkg::REG_CRIT_THR:   thr_crit   = data;
      tsdc_pkg::REG_WARN_PER:   warn_per   = data[tsdc_pkg::TMR_W-1:0];
      tsdc_pkg::REG_ON_TIME:    on_time    = data[tsdc_pkg::TMR_W-1:0];
      tsdc_pkg::REG_OFF_TIME:   off_time   = data[tsdc_pkg::TMR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int nthr, input int wthr, input int cthr,
                            input int per, input int ton, input int toff);
    write_reg(tsdc_pkg::REG_NORMAL_THR, nthr);
    write_reg(tsdc_pkg::REG_WARN_THR, wthr);
    write_reg(tsdc_pkg::REG_CRIT_THR, cthr);
    write_reg(tsdc_pkg::REG_WARN_PER, per);
    write_reg(tsdc_pkg::REG_ON_TIME, ton);
    write_reg(tsdc_pkg::REG_OFF_TIME, toff);
  endtask

  // Block until every tick is sent and answered, then let the pipe settle.
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || solenoid_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_tick(input int l, input int r, input int b, input logic m);
    tick_t t;
    t.manual      = m;
    t.drain_first = 1'b0;
    t.temp[0]     = l[tsdc_pkg::TEMP_W-1:0];
    t.temp[1]     = r[tsdc_pkg::TEMP_W-1:0];
    t.temp[2]     = b[tsdc_pkg::TEMP_W-1:0];
    tick_q.push_back(t);
  endtask

  // Pick a temperature inside the band of one level under the current
  // thresholds; mostly within the sensor's working range.
  function automatic int temp_in_band(input logic [tsdc_pkg::LVL_W-1:0] lvl);
    int lo, hi, lo_op, hi_op;
    case (lvl)
      tsdc_pkg::LVL_CRIT:   begin lo = int'(thr_crit) + 1;   hi = TEMP_MAX; end
      tsdc_pkg::LVL_WARN:   begin lo = int'(thr_warn) + 1;   hi = int'(thr_crit); end
      tsdc_pkg::LVL_NORMAL: begin lo = int'(thr_normal) + 1; hi = int'(thr_warn); end
      default:              begin lo = TEMP_MIN;             hi = int'(thr_normal); end
    endcase
    if (lo > hi) return TEMP_MIN + int'($urandom_range(TEMP_MAX - TEMP_MIN, 0));
    lo_op = (lo < OPER_MIN) ? OPER_MIN : lo;
    hi_op = (hi > OPER_MAX) ? OPER_MAX : hi;
    if (lo_op <= hi_op && $urandom_range(7, 0) != 0) begin
      lo = lo_op;
      hi = hi_op;
    end
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Random ticks: each channel dwells in one level for a random stretch so the
  // timers get to run out, with noise and near-threshold values mixed in.
  task automatic run_random(input int n);
    tick_t                      t;
    int                         seg_left [tsdc_pkg::NUM_CH];
    logic [tsdc_pkg::LVL_W-1:0] seg_lvl [tsdc_pkg::NUM_CH];
    int                         man_left, v, pick;
    logic                       man;
    man_left = 0;
    man      = 1'b0;
    for (int c = 0; c < tsdc_pkg::NUM_CH; c++) seg_left[c] = 0;
    for (int k = 0; k < n; k++) begin
      if (man_left == 0) begin
        man      = ($urandom_range(7, 0) == 0);
        man_left = $urandom_range(20, 1);
      end
      man_left--;
      for (int c = 0; c < tsdc_pkg::NUM_CH; c++) begin
        if (seg_left[c] == 0) begin
          seg_lvl[c]  = tsdc_pkg::LVL_W'($urandom_range(3, 0));
          seg_left[c] = $urandom_range(40, 1);
        end
        seg_left[c]--;
        pick = $urandom_range(15, 0);
        if (pick == 0) begin
          v = $urandom;
        end else if (pick == 1) begin
          case ($urandom_range(2, 0))
            0:       v = int'(thr_normal);
            1:       v = int'(thr_warn);
            default: v = int'(thr_crit);
          endcase
          v = v + int'($urandom_range(4, 0)) - 2;
        end else begin
          v = temp_in_band(seg_lvl[c]);
        end
        t.temp[c] = v[tsdc_pkg::TEMP_W-1:0];
      end
      t.manual      = man;
      // pause the sender for a full drain mid-phase and now and then
      t.drain_first = (k == n / 2) || ($urandom_range(99, 0) == 0);
      tick_q.push_back(t);
    end
  endtask

  initial begin
    int a, b, c, s;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks under the reset thresholds: field extremes, each side of
    // each threshold, mixed levels across channels, manual hold.
    add_tick(TEMP_MIN, TEMP_MAX, 0, 1'b0);
    add_tick(TEMP_MAX, TEMP_MIN, -1, 1'b1);
    add_tick(OPER_MIN, OPER_MAX, int'(tsdc_pkg::RST_NORMAL_THR), 1'b0);
    add_tick(int'(tsdc_pkg::RST_NORMAL_THR) + 1, int'(tsdc_pkg::RST_WARN_THR),
             int'(tsdc_pkg::RST_WARN_THR) + 1, 1'b0);
    add_tick(int'(tsdc_pkg::RST_CRIT_THR), int'(tsdc_pkg::RST_CRIT_THR) + 1, OPER_MAX, 1'b0);
    add_tick(int'(tsdc_pkg::RST_CRIT_THR) + 1, int'(tsdc_pkg::RST_WARN_THR) + 2, 700, 1'b0);
    add_tick(700, int'(tsdc_pkg::RST_CRIT_THR) + 1, int'(tsdc_pkg::RST_WARN_THR) + 2, 1'b1);
    add_tick(700, 700, 700, 1'b1);
    add_tick(0, 0, 0, 1'b0);
    add_tick(12'h555, 12'hAAA, TEMP_MAX, 1'b0);
    add_tick(12'hAAA, 12'h555, TEMP_MIN, 1'b1);
    add_tick(TEMP_MAX, TEMP_MAX, TEMP_MAX, 1'b0);
    add_tick(TEMP_MIN, TEMP_MIN, TEMP_MIN, 1'b0);
    run_random(250);
    wait_drained();

    // Short periods: frequent warning toggles and normal duty cycling.
    set_config(100, 400, 800, 3, 2, 4);
    run_random(250);
    wait_drained();

    // Zero periods: every due channel changes each tick, once only.
    set_config(OPER_MIN, 0, OPER_MAX, 0, 0, 0);
    run_random(200);
    wait_drained();

    // Thresholds out of order, plus writes to the unused slots.
    set_config(OPER_MAX, 500, OPER_MIN, 1, 3, 1);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    run_random(150);
    wait_drained();

    // Full-scale periods: the timers saturate and nothing timed ever fires.
    set_config(TEMP_MIN, 1000, TEMP_MAX, 255, 255, 255);
    run_random(300);
    wait_drained();

    // Random sorted thresholds with short periods.
    repeat (2) begin
      a = OPER_MIN + int'($urandom_range(OPER_MAX - OPER_MIN, 0));
      b = OPER_MIN + int'($urandom_range(OPER_MAX - OPER_MIN, 0));
      c = OPER_MIN + int'($urandom_range(OPER_MAX - OPER_MIN, 0));
      if (a > b) begin s = a; a = b; b = s; end
      if (b > c) begin s = b; b = c; c = s; end
      if (a > b) begin s = a; a = b; b = s; end
      set_config(a, b, c, $urandom_range(12, 0), $urandom_range(12, 0),
                 $urandom_range(12, 0));
      run_random(200);
      wait_drained();
    end

    repeat (TAIL_CYC) @(posedge clk);
    if (mism_cnt == 0)
      $display("[thermal_solenoid_duty_controller] OK");
    else
      $display("[thermal_solenoid_duty_controller] ERROR");
    $finish;
  end

endmodule

### thermal_solenoid_duty_controller.f
sv/tsdc_pkg.sv
sv/tsdc_lane.sv
sv/tsdc_merge.sv
sv/thermal_solenoid_duty_controller.sv
sv/tsdc_checker.sv
tb/sv/tb_thermal_solenoid_duty_controller.sv
